### rtl/alfs_pkg.sv
// shared types and constants for the addressable led frame serializer
// used by alfs_ctrl, alfs_datapath and the top level; no dependencies
package alfs_pkg;

   // command codes of an input beat; six and seven do nothing
   typedef enum logic [2:0] {
      CMD_GRID  = 3'd0,
      CMD_INDEX = 3'd1,
      CMD_FILL  = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_SHOW  = 3'd4,
      CMD_TICK  = 3'd5
   } cmd_type;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      CSR_COLOR_ORDER = 2'd0,
      CSR_COLUMNS     = 2'd1,
      CSR_LED_COUNT   = 2'd2,
      CSR_LATCH_GAP   = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // line patterns for one data bit
   localparam logic [14:0] SYM_ONE  = 15'h7FE0;
   localparam logic [14:0] SYM_ZERO = 15'h7C00;

   localparam int COLOUR_W  = 24;
   localparam int PROD_W    = 18;   // (y+1)*columns fits 256*511
   localparam int CSR_W     = 10;
   localparam int BIT_FIRST = 7;

   localparam logic       COLOR_ORDER_RST = 1'b1;
   localparam logic [8:0] COLUMNS_RST     = 9'd16;
   localparam logic [8:0] LED_COUNT_RST   = 9'd256;
   localparam logic [9:0] LATCH_GAP_RST   = 10'd40;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the request beat
      logic decode;   // grid product and store read
      logic sweep;    // write one store entry of a fill or clear pass
      logic zero;     // sweep writes zero
      logic finish;   // commit the command and register the result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    sending;
      logic    sweep_done;
   } sts_type;

endpackage

### rtl/addressable_led_frame_serializer_top.sv
// Frame serializer for a chain of addressable RGB LEDs in a serpentine
// matrix. A command is taken when start is high and busy is low; its single
// result beat appears on the rsp_ ports for one cycle, flagged by rsp_strobe,
// and cannot be held off. Each command goes from idle through a decode state
// to a finish state, whose end registers its result beat; a fill or clear
// that goes ahead passes through a sweep state in between, walking the pixel
// store one entry per cycle through its single write port, and one refused
// during a frame skips it. busy stays high until the controller is back in
// idle, so a new command is taken only after the last one's result beat.
// After reset the store is cleared by the same walk, during which busy
// stays high; csr writes are taken at any time (csr_ready is always high) but
// should be made only while the block is idle.
// depends on alfs_pkg, alfs_ctrl and alfs_datapath
module addressable_led_frame_serializer_top #(
   parameter int MAX_LEDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_x_coord,
   input  logic [7:0]  req_y_coord,
   input  logic [9:0]  req_pixel_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_strobe,
   output logic        rsp_accepted,
   output logic [14:0] rsp_symbol,
   output logic        rsp_symbol_valid,
   output logic        rsp_frame_last,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [alfs_pkg::CSR_W-1:0] csr_data
);
   import alfs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   alfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   alfs_datapath #(
      .MAX_LEDS (MAX_LEDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_command),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_pixel_index  (req_pixel_index),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_accepted     (rsp_accepted),
      .rsp_symbol       (rsp_symbol),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_busy_res     (rsp_busy_res)
   );

endmodule

### rtl/alfs_ctrl.sv
// sequencer for the led frame serializer: one state machine that steps each
// command through decode, an optional store sweep and commit; uses alfs_pkg
module alfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  alfs_pkg::sts_type sts,
   output alfs_pkg::ctl_type ctl
);
   import alfs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_INIT: begin
            // store clearing pass after reset
            ctl.sweep = 1'b1;
            ctl.zero  = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl.decode = 1'b1;
            if ((sts.cmd == CMD_FILL || sts.cmd == CMD_CLEAR) && !sts.sending) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            ctl.sweep = 1'b1;
            ctl.zero  = (sts.cmd == CMD_CLEAR);
            if (sts.sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/alfs_datapath.sv
// datapath of the led frame serializer: csr registers, pixel store memory,
// address arithmetic, frame position counters and result registers; uses alfs_pkg
module alfs_datapath #(
   parameter int MAX_LEDS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  alfs_pkg::ctl_type       ctl,
   output alfs_pkg::sts_type       sts,
   input  logic [2:0]              req_command,
   input  logic [7:0]              req_x_coord,
   input  logic [7:0]              req_y_coord,
   input  logic [9:0]              req_pixel_index,
   input  logic [7:0]              req_red,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_blue,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [alfs_pkg::CSR_W-1:0] csr_data,
   output logic                    rsp_strobe,
   output logic                    rsp_accepted,
   output logic [14:0]             rsp_symbol,
   output logic                    rsp_symbol_valid,
   output logic                    rsp_frame_last,
   output logic                    rsp_busy_res
);
   import alfs_pkg::*;

   localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CNT_W = $clog2(MAX_LEDS + 1);
   localparam int ACT_W = (CNT_W > 9) ? CNT_W : 9;

   // configuration
   logic       color_order_ff;
   logic [8:0] columns_ff;
   logic [8:0] led_count_ff;
   logic [9:0] latch_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_order_ff <= COLOR_ORDER_RST;
         columns_ff     <= COLUMNS_RST;
         led_count_ff   <= LED_COUNT_RST;
         latch_gap_ff   <= LATCH_GAP_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_COLOR_ORDER: color_order_ff <= csr_data[0];
            CSR_COLUMNS:     columns_ff     <= csr_data[8:0];
            CSR_LED_COUNT:   led_count_ff   <= csr_data[8:0];
            CSR_LATCH_GAP:   latch_gap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // captured request beat
   cmd_type             cmd_ff;
   logic [7:0]          x_ff;
   logic [7:0]          y_ff;
   logic [9:0]          pidx_ff;
   logic [COLOUR_W-1:0] colour_ff;
   logic [PROD_W-1:0]   product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_SHOW;
      end else if (ctl.load) begin
         cmd_ff <= cmd_type'(req_command);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff      <= req_x_coord;
         y_ff      <= req_y_coord;
         pidx_ff   <= req_pixel_index;
         colour_ff <= color_order_ff ? {req_green, req_red, req_blue}
                                     : {req_red, req_green, req_blue};
      end
      // odd rows run right to left, so they count back from the row end
      if (ctl.decode) begin
         product_ff <= PROD_W'({1'b0, y_ff} + {8'd0, y_ff[0]}) * PROD_W'(columns_ff);
      end
   end

   // effective led count: clamp to the store, zero acts as one
   logic [ACT_W-1:0] active;
   always_comb begin
      active = ACT_W'(led_count_ff);
      if (active > ACT_W'(MAX_LEDS)) begin
         active = ACT_W'(MAX_LEDS);
      end
      if (active == '0) begin
         active = ACT_W'(1);
      end
   end

   // frame state
   logic            sending_ff, sending_in;
   logic            pending_ff, pending_in;
   logic [AW-1:0]   led_pos_ff, led_pos_in;
   logic [1:0]      byte_pos_ff, byte_pos_in;
   logic [2:0]      bit_pos_ff, bit_pos_in;
   logic [9:0]      gap_ff, gap_in;
   logic [AW-1:0]   sweep_ptr_ff, sweep_ptr_in;

   // pixel store
   logic [COLOUR_W-1:0] store_mem [MAX_LEDS];
   logic [COLOUR_W-1:0] rd_data_ff;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [COLOUR_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (ctl.decode) begin
         rd_data_ff <= store_mem[led_pos_ff];
      end
   end

   logic              sweep_done;
   logic [PROD_W-1:0] set_num;
   logic              set_in_range;
   logic              set_ok;
   logic [7:0]        cur_byte;
   logic              cur_bit;
   logic              emit;
   logic              last;
   logic              acc;
   logic [14:0]       sym;

   assign sweep_done = (sweep_ptr_ff == AW'(MAX_LEDS - 1));

   always_comb begin
      sending_in   = sending_ff;
      pending_in   = pending_ff;
      led_pos_in   = led_pos_ff;
      byte_pos_in  = byte_pos_ff;
      bit_pos_in   = bit_pos_ff;
      gap_in       = gap_ff;
      sweep_ptr_in = sweep_ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = sweep_ptr_ff;
      wr_data      = ctl.zero ? '0 : colour_ff;
      emit         = 1'b0;
      last         = 1'b0;
      acc          = 1'b0;
      sym          = '0;
      set_num      = PROD_W'(pidx_ff);
      set_in_range = 1'b1;

      // target of a set command
      if (cmd_ff == CMD_GRID) begin
         if (y_ff[0]) begin
            set_in_range = (PROD_W'(x_ff) < product_ff);
            set_num      = product_ff - PROD_W'(x_ff) - PROD_W'(1);
         end else begin
            set_num = product_ff + PROD_W'(x_ff);
         end
      end
      set_ok = set_in_range && (set_num < PROD_W'(active)) && !sending_ff;

      case (byte_pos_ff)
         2'd0:    cur_byte = rd_data_ff[23:16];
         2'd1:    cur_byte = rd_data_ff[15:8];
         2'd2:    cur_byte = rd_data_ff[7:0];
         default: cur_byte = '0;
      endcase
      cur_bit = cur_byte[bit_pos_ff];

      if (ctl.sweep) begin
         wr_en        = 1'b1;
         sweep_ptr_in = sweep_done ? '0 : sweep_ptr_ff + AW'(1);
      end

      if (ctl.finish) begin
         case (cmd_ff)
            CMD_GRID, CMD_INDEX: begin
               acc     = set_ok;
               wr_en   = set_ok;
               wr_addr = set_num[AW-1:0];
               wr_data = colour_ff;
            end
            CMD_FILL, CMD_CLEAR: begin
               acc = !sending_ff;
            end
            CMD_SHOW: begin
               acc        = 1'b1;
               pending_in = 1'b1;
            end
            CMD_TICK: begin
               // positions sit at led 0, first byte, top bit whenever idle
               if (sending_ff) begin
                  emit = 1'b1;
               end else if (gap_ff != '0) begin
                  gap_in = gap_ff - 10'd1;
               end else if (pending_ff) begin
                  emit       = 1'b1;
                  pending_in = 1'b0;
               end
               if (emit) begin
                  sym = cur_bit ? SYM_ONE : SYM_ZERO;
                  if (bit_pos_ff != 3'd0) begin
                     bit_pos_in = bit_pos_ff - 3'd1;
                  end else begin
                     bit_pos_in = 3'(BIT_FIRST);
                     if (byte_pos_ff < 2'd2) begin
                        byte_pos_in = byte_pos_ff + 2'd1;
                     end else begin
                        byte_pos_in = 2'd0;
                        if (ACT_W'(led_pos_ff) + ACT_W'(1) >= active) begin
                           led_pos_in = '0;
                           gap_in     = latch_gap_ff;
                           last       = 1'b1;
                        end else begin
                           led_pos_in = led_pos_ff + AW'(1);
                        end
                     end
                  end
                  sending_in = !last;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         led_pos_ff   <= '0;
         byte_pos_ff  <= 2'd0;
         bit_pos_ff   <= 3'(BIT_FIRST);
         gap_ff       <= '0;
         sweep_ptr_ff <= '0;
         rsp_strobe   <= 1'b0;
      end else begin
         sending_ff   <= sending_in;
         pending_ff   <= pending_in;
         led_pos_ff   <= led_pos_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
         gap_ff       <= gap_in;
         sweep_ptr_ff <= sweep_ptr_in;
         rsp_strobe   <= ctl.finish;
      end
   end

   // result beat registers
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_accepted     <= acc;
         rsp_symbol       <= sym;
         rsp_symbol_valid <= emit;
         rsp_frame_last   <= last;
         rsp_busy_res     <= sending_in || pending_in || (gap_in != '0);
      end
   end

   assign sts.cmd        = cmd_ff;
   assign sts.sending    = sending_ff;
   assign sts.sweep_done = sweep_done;

endmodule

### tb/sv/addressable_led_frame_serializer_top_tb.sv
// self-checking testbench for addressable_led_frame_serializer_top: a queue-fed
// command driver, a result monitor with its own model of store, frame and gap
// depends on alfs_pkg and the top level of the block
module addressable_led_frame_serializer_top_tb;
   import alfs_pkg::*;

   localparam int LED_SLOTS   = 256;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE      = 12;
   localparam int REPORT_MAX  = 10;
   localparam int BITS_PER_LED = 24;

   // command codes the block ignores
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] x_coord;
      logic [7:0] y_coord;
      logic [9:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } led_cmd_t;

   typedef struct packed {
      logic        accepted;
      logic [14:0] symbol;
      logic        symbol_valid;
      logic        frame_last;
      logic        busy_res;
   } line_beat_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_command = '0;
   logic [7:0]        req_x_coord = '0;
   logic [7:0]        req_y_coord = '0;
   logic [9:0]        req_pixel_index = '0;
   logic [7:0]        req_red = '0;
   logic [7:0]        req_green = '0;
   logic [7:0]        req_blue = '0;
   logic              rsp_strobe;
   logic              rsp_accepted;
   logic [14:0]       rsp_symbol;
   logic              rsp_symbol_valid;
   logic              rsp_frame_last;
   logic              rsp_busy_res;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [CSR_W-1:0]  csr_data = '0;

   always #5 clock = ~clock;

   addressable_led_frame_serializer_top #(
      .MAX_LEDS(LED_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord),
      .req_pixel_index(req_pixel_index),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_strobe(rsp_strobe),
      .rsp_accepted(rsp_accepted),
      .rsp_symbol(rsp_symbol),
      .rsp_symbol_valid(rsp_symbol_valid),
      .rsp_frame_last(rsp_frame_last),
      .rsp_busy_res(rsp_busy_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   led_cmd_t   command_queue[$];
   line_beat_t expected_beats[$];
   logic       req_taken = 1'b0;
   int         burst_left = 1;
   int         idle_left = 0;
   int         quiet_cycles = 0;
   int         error_count = 0;
   int         cmd_count = 0;
   int         symbol_count = 0;
   int         frame_count = 0;
   int         refused_count = 0;
   int         csr_count = 0;

   // mirror of the block state and its registers
   logic [COLOUR_W-1:0] pixel_mirror [LED_SLOTS];
   logic                mir_sending;
   logic                mir_pending;
   int unsigned         mir_led;
   int unsigned         mir_byte;
   int unsigned         mir_bit;
   int unsigned         mir_gap;
   logic                cfg_grb;
   int unsigned         cfg_columns;
   int unsigned         cfg_leds;
   int unsigned         cfg_gap;

   function automatic int unsigned leds_in_use();
      if (cfg_leds > LED_SLOTS) return LED_SLOTS;
      if (cfg_leds == 0) return 1;
      return cfg_leds;
   endfunction

   function automatic logic store_write(int unsigned num, logic [COLOUR_W-1:0] colour);
      if (mir_sending || num >= leds_in_use()) return 1'b0;
      pixel_mirror[num] = colour;
      return 1'b1;
   endfunction

   // one data bit of the frame: led by led, bytes in store order, msb first
   function automatic logic [14:0] next_symbol(output logic last);
      logic [COLOUR_W-1:0] word;
      logic [7:0]          byte_val;
      word = pixel_mirror[mir_led] >> (8 * (2 - mir_byte));
      byte_val = word[7:0];
      next_symbol = byte_val[mir_bit] ? SYM_ONE : SYM_ZERO;
      last = 1'b0;
      if (mir_bit > 0) begin
         mir_bit--;
      end else begin
         mir_bit = BIT_FIRST;
         if (mir_byte < 2) begin
            mir_byte++;
         end else begin
            mir_byte = 0;
            // a count shrunk mid-frame ends it after the current led
            if (mir_led + 1 >= leds_in_use()) begin
               mir_led = 0;
               mir_sending = 1'b0;
               mir_gap = cfg_gap;
               last = 1'b1;
            end else begin
               mir_led++;
            end
         end
      end
   endfunction

   task automatic predict_line_beat(input led_cmd_t c, output line_beat_t r);
      logic [COLOUR_W-1:0] colour;
      int unsigned         xi, yi, row_end;
      logic                last;
      r = '0;
      last = 1'b0;
      xi = 32'(c.x_coord);
      yi = 32'(c.y_coord);
      colour = cfg_grb ? {c.green, c.red, c.blue} : {c.red, c.green, c.blue};
      case (c.command)
         CMD_GRID: begin
            // odd rows run right to left; a column that would land before led 0 is refused
            if (yi[0]) begin
               row_end = (yi + 1) * cfg_columns;
               if (xi < row_end) r.accepted = store_write(row_end - xi - 1, colour);
            end else begin
               r.accepted = store_write(yi * cfg_columns + xi, colour);
            end
         end
         CMD_INDEX: r.accepted = store_write(32'(c.pixel_index), colour);
         CMD_FILL, CMD_CLEAR: begin
            if (!mir_sending) begin
               for (int i = 0; i < LED_SLOTS; i++)
                  pixel_mirror[i] = (c.command == CMD_FILL) ? colour : '0;
               r.accepted = 1'b1;
            end
         end
         CMD_SHOW: begin
            mir_pending = 1'b1;
            r.accepted = 1'b1;
         end
         CMD_TICK: begin
            if (mir_sending) begin
               r.symbol = next_symbol(last);
               r.symbol_valid = 1'b1;
            end else if (mir_gap > 0) begin
               mir_gap--;
            end else if (mir_pending) begin
               mir_pending = 1'b0;
               mir_sending = 1'b1;
               mir_led = 0;
               mir_byte = 0;
               mir_bit = BIT_FIRST;
               r.symbol = next_symbol(last);
               r.symbol_valid = 1'b1;
            end
            r.frame_last = last;
         end
         default: ;
      endcase
      r.busy_res = mir_sending || mir_pending || (mir_gap > 0);
   endtask

   // command driver: bursts of beats with random pauses between them
   always @(negedge clock) begin : driver
      led_cmd_t nxt;
      if (!reset && (!start || req_taken)) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (command_queue.size() != 0) begin
            nxt = command_queue.pop_front();
            req_command     <= nxt.command;
            req_x_coord     <= nxt.x_coord;
            req_y_coord     <= nxt.y_coord;
            req_pixel_index <= nxt.pixel_index;
            req_red         <= nxt.red;
            req_green       <= nxt.green;
            req_blue        <= nxt.blue;
            start           <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 5))
                  0, 1: idle_left = 0;
                  5: idle_left = $urandom_range(8, 30);
                  default: idle_left = $urandom_range(1, 7);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      line_beat_t want, got;
      led_cmd_t   c;
      if (reset) begin
         for (int i = 0; i < LED_SLOTS; i++) pixel_mirror[i] = '0;
         mir_sending = 1'b0;
         mir_pending = 1'b0;
         mir_led = 0;
         mir_byte = 0;
         mir_bit = BIT_FIRST;
         mir_gap = 0;
         cfg_grb = COLOR_ORDER_RST;
         cfg_columns = 32'(COLUMNS_RST);
         cfg_leds = 32'(LED_COUNT_RST);
         cfg_gap = 32'(LATCH_GAP_RST);
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (csr_valid && csr_ready) begin
            csr_count++;
            case (csr_index)
               CSR_COLOR_ORDER: cfg_grb = csr_data[0];
               CSR_COLUMNS:     cfg_columns = 32'(csr_data[8:0]);
               CSR_LED_COUNT:   cfg_leds = 32'(csr_data[8:0]);
               CSR_LATCH_GAP:   cfg_gap = 32'(csr_data);
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            got = {rsp_accepted, rsp_symbol, rsp_symbol_valid, rsp_frame_last, rsp_busy_res};
            if (expected_beats.size() == 0) begin
               if (error_count < REPORT_MAX)
                  $display("%0t: result beat with nothing outstanding", $realtime);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got.accepted !== want.accepted || got.symbol !== want.symbol ||
                   got.symbol_valid !== want.symbol_valid ||
                   got.frame_last !== want.frame_last || got.busy_res !== want.busy_res) begin
                  if (error_count < REPORT_MAX) begin
                     $display("%0t: mismatch, expected acc %0b sym %h valid %0b last %0b busy %0b",
                              $realtime, want.accepted, want.symbol, want.symbol_valid,
                              want.frame_last, want.busy_res);
                     $display("   got acc %0b sym %h valid %0b last %0b busy %0b",
                              got.accepted, got.symbol, got.symbol_valid,
                              got.frame_last, got.busy_res);
                  end
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            c = {req_command, req_x_coord, req_y_coord, req_pixel_index,
                 req_red, req_green, req_blue};
            predict_line_beat(c, want);
            expected_beats.push_back(want);
            cmd_count++;
            symbol_count += int'(want.symbol_valid);
            frame_count += int'(want.frame_last);
            if (!want.accepted && (c.command == CMD_GRID || c.command == CMD_INDEX ||
                                   c.command == CMD_FILL || c.command == CMD_CLEAR))
               refused_count++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_cmd(input logic [2:0] op, input logic [7:0] x, y,
                           input logic [9:0] idx, input logic [7:0] r, g, b);
      command_queue.push_back({op, x, y, idx, r, g, b});
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 10'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_random_cmd(input int n_act, input int ncols, output int counted);
      int         sel, lin, row;
      logic [2:0] op;
      logic [7:0] x, y;
      logic [9:0] idx;
      x = 8'($urandom);
      y = 8'($urandom);
      idx = 10'($urandom);
      counted = 1;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         op = CMD_TICK;
      end else if (sel < 55) begin
         op = CMD_GRID;
         // mostly a position that lands inside the chain
         if (sel < 50) begin
            lin = $urandom_range(0, n_act - 1);
            row = lin / ncols;
            y = 8'(row);
            x = 8'(row[0] ? ncols - 1 - lin % ncols : lin % ncols);
         end
      end else if (sel < 75) begin
         op = CMD_INDEX;
         if (sel < 70) idx = 10'($urandom_range(0, n_act + 1));
      end else if (sel < 87) begin
         op = CMD_SHOW;
      end else if (sel < 92) begin
         op = CMD_FILL;
      end else if (sel < 96) begin
         op = CMD_CLEAR;
      end else begin
         op = sel[0] ? CMD_SPARE7 : CMD_SPARE6;
         counted = 0;
      end
      push_cmd(op, x, y, idx, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // show then ticks, mostly enough for the frame and its gap, with random commands mixed in
   task automatic push_frame_burst(input int n_act, ncols, gap, output int counted);
      int n_ticks, k;
      push_cmd(CMD_SHOW, 8'($urandom), 8'($urandom), 10'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
      counted = 1;
      n_ticks = n_act * BITS_PER_LED + gap + $urandom_range(0, 6);
      if ($urandom_range(0, 4) == 0) n_ticks = $urandom_range(1, n_act * BITS_PER_LED);
      repeat (n_ticks) begin
         if ($urandom_range(0, 5) == 0) begin
            push_random_cmd(n_act, ncols, k);
            counted += k;
         end
         push_ticks(1);
         counted++;
      end
   endtask

   task automatic drain(input int settle);
      while (command_queue.size() != 0 || start || expected_beats.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_registers(input logic [CSR_W-1:0] order_data, cols, count, gap);
      csr_write(CSR_COLOR_ORDER, order_data);
      csr_write(CSR_COLUMNS, cols);
      csr_write(CSR_LED_COUNT, count);
      csr_write(CSR_LATCH_GAP, gap);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n_items, input logic [CSR_W-1:0] order_data,
                               cols, count, gap);
      int n_act, made, k;
      drain(SETTLE);
      set_registers(order_data, cols, count, gap);
      n_act = (count[8:0] == 0) ? 1 : int'(count[8:0]);
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 11) == 0)
            push_frame_burst(n_act, int'(cols[8:0]), int'(gap), k);
         else push_random_cmd(n_act, int'(cols[8:0]), k);
         made += k;
      end
   endtask

   initial begin : stimulus
      int k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: grb order, 16 columns, 256 leds
      push_cmd(CMD_INDEX, 0, 0, 0, 8'hFF, 8'h00, 8'hA5);
      push_cmd(CMD_INDEX, 0, 0, 255, 8'h00, 8'hFF, 8'h5A);
      push_cmd(CMD_INDEX, 0, 0, 256, 8'h11, 8'h22, 8'h33);
      push_cmd(CMD_INDEX, 8'hFF, 8'hFF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_GRID, 0, 0, 0, 8'h12, 8'h34, 8'h56);
      push_cmd(CMD_GRID, 255, 0, 0, 8'h01, 8'h80, 8'hFE);
      push_cmd(CMD_GRID, 0, 1, 0, 8'h9C, 8'h3D, 8'h0F);
      push_cmd(CMD_GRID, 40, 1, 0, 8'h77, 8'h77, 8'h77);
      push_cmd(CMD_GRID, 15, 15, 0, 8'hC0, 8'h03, 8'h18);
      push_cmd(CMD_GRID, 255, 255, 0, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_GRID, 0, 254, 0, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_FILL, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_CLEAR, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_FILL, 0, 0, 0, 8'h80, 8'h01, 8'h7F);
      push_cmd(CMD_INDEX, 0, 0, 1, 8'hAA, 8'h55, 8'hC3);
      push_cmd(CMD_SPARE6, 8'hFF, 8'hFF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_SPARE7, 0, 0, 0, 0, 0, 0);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(6);
      // writes while the frame goes out are refused, a show is kept
      push_cmd(CMD_INDEX, 0, 0, 2, 8'h01, 8'h02, 8'h03);
      push_cmd(CMD_GRID, 1, 0, 0, 8'h01, 8'h02, 8'h03);
      push_cmd(CMD_FILL, 0, 0, 0, 8'h01, 8'h02, 8'h03);
      push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(4);

      // count of zero acts as one led and cuts the running frame short
      drain(SETTLE);
      set_registers(10'h000, 10'd1, 10'd0, 10'd0);
      push_ticks(30);
      push_cmd(CMD_INDEX, 0, 0, 0, 8'h5A, 8'hA5, 8'h3C);
      push_cmd(CMD_INDEX, 0, 0, 1, 8'h5A, 8'hA5, 8'h3C);
      push_cmd(CMD_GRID, 0, 0, 0, 8'hE1, 8'h1E, 8'h99);
      push_cmd(CMD_GRID, 0, 1, 0, 8'hE1, 8'h1E, 8'h99);
      push_cmd(CMD_GRID, 1, 0, 0, 8'hE1, 8'h1E, 8'h99);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(26);

      // rows of 256 columns and a count above the store size
      drain(SETTLE);
      set_registers(10'h3FF, 10'h100, 10'h1FF, 10'd5);
      push_cmd(CMD_GRID, 255, 0, 0, 8'h0F, 8'hF0, 8'h55);
      push_cmd(CMD_GRID, 0, 1, 0, 8'h0F, 8'hF0, 8'h55);
      push_cmd(CMD_GRID, 255, 1, 0, 8'h0F, 8'hF0, 8'h55);
      push_cmd(CMD_INDEX, 0, 0, 255, 8'hFF, 8'h00, 8'hFF);
      push_cmd(CMD_FILL, 0, 0, 0, 8'h01, 8'h02, 8'h03);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(30);
      push_cmd(CMD_INDEX, 0, 0, 3, 8'h01, 8'h02, 8'h03);

      random_phase(360, 10'($urandom), 10'd3, 10'd5, 10'd3);
      random_phase(360, 10'($urandom), 10'h1FF, 10'd4, 10'd0);
      random_phase(360, 10'($urandom), 10'($urandom_range(1, 8)),
                   10'($urandom_range(1, 6)), 10'($urandom_range(0, 8)));
      random_phase(360, 10'($urandom), 10'd2, 10'd0, 10'd7);
      random_phase(360, 10'($urandom), 10'($urandom_range(1, 8)),
                   10'($urandom_range(2, 8)), 10'($urandom_range(1, 4)));

      // longest latch gap: writes and shows while it runs
      drain(SETTLE);
      set_registers(10'h000, 10'd255, 10'd1, 10'h3FF);
      push_cmd(CMD_INDEX, 0, 0, 0, 8'hC3, 8'h3C, 8'h81);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(34);
      push_cmd(CMD_INDEX, 0, 0, 0, 8'h7E, 8'hE7, 8'h42);
      push_cmd(CMD_FILL, 0, 0, 0, 8'h24, 8'h42, 8'h99);
      push_cmd(CMD_GRID, 0, 0, 0, 8'h10, 8'h20, 8'h30);
      push_cmd(CMD_SHOW, 0, 0, 0, 0, 0, 0);
      push_ticks(20);
      repeat (60) push_random_cmd(1, 255, k);

      drain(2 * SETTLE);
      $display("ran %0d commands: %0d line symbols, %0d whole frames, %0d refused writes",
               cmd_count, symbol_count, frame_count, refused_count);
      $display("%0d register writes, %0d result mismatches", csr_count, error_count);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/alfs_pkg.sv
rtl/alfs_ctrl.sv
rtl/alfs_datapath.sv
rtl/addressable_led_frame_serializer_top.sv
tb/sv/addressable_led_frame_serializer_top_tb.sv
